FILE: src/partial_tracker_frame_match_unit_macros.svh
// Assertion macros for the partial tracker frame match unit.
`ifndef PARTIAL_TRACKER_FRAME_MATCH_UNIT_MACROS_SVH
`define PARTIAL_TRACKER_FRAME_MATCH_UNIT_MACROS_SVH

// Checked only out of reset.
`define PTFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/ptfm_pkg.sv
// Shared types, constants and helpers for the partial tracker frame match unit.
package ptfm_pkg;

  localparam int unsigned MaxPeaksDefault = 64;
  localparam int unsigned IdBitsDefault   = 20;
  localparam int unsigned FreqW           = 19;
  localparam int unsigned OffW            = 17;
  localparam int unsigned FsW             = 40;
  localparam int unsigned TimeW           = 44;
  localparam int unsigned PassW           = 16;
  localparam logic [FreqW-1:0] DriftReset = FreqW'(480);

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [OffW-1:0]  offset;
    logic [PassW-1:0] amp;
    logic [PassW-1:0] bw;
    logic [PassW-1:0] phase;
  } peak_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } sort_op_t;

  typedef struct packed {
    logic shift;
    logic load;
  } elig_op_t;

  function automatic logic [FreqW-1:0] absdiff(input logic [FreqW-1:0] a,
                                               input logic [FreqW-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  // frame_sample*16 + offset, clamped to the 44-bit range
  function automatic logic [TimeW-1:0] bp_time(input logic [FsW-1:0] fs,
                                               input logic [OffW-1:0] off);
    logic signed [TimeW+1:0] s;
    s = $signed({2'b00, fs, 4'b0000}) + (TimeW+2)'($signed(off));
    if (s[TimeW+1])   bp_time = '0;
    else if (s[TimeW]) bp_time = '1;
    else              bp_time = s[TimeW-1:0];
  endfunction

endpackage

FILE: src/ptfm_sort_cell.sv
// One cell of the insertion-sort row: holds one buffered peak.
module ptfm_sort_cell import ptfm_pkg::*; (
  input  logic     clk_i,
  input  sort_op_t op_i,
  input  logic     vld_i,
  input  peak_t    key_i,
  input  peak_t    left_i,
  input  logic     left_gt_i,
  input  peak_t    right_i,
  output logic     gt_o,
  output peak_t    data_o
);

  peak_t data_q, data_d;

  // empty cells count as greater so the key lands after the last valid entry
  assign gt_o = !vld_i || (data_q.freq > key_i.freq);

  always_comb begin
    data_d = data_q;
    if (op_i.insert) begin
      if (left_gt_i)  data_d = left_i;
      else if (gt_o)  data_d = key_i;
    end else if (op_i.pop) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/ptfm_elig_cell.sv
// One cell of a partial row: id, end frequency and end time of one partial.
module ptfm_elig_cell import ptfm_pkg::*; #(
  parameter int unsigned IdBits = IdBitsDefault
) (
  input  logic              clk_i,
  input  elig_op_t          op_i,
  input  logic [IdBits-1:0] right_id_i,
  input  logic [FreqW-1:0]  right_freq_i,
  input  logic [TimeW-1:0]  right_time_i,
  input  logic [IdBits-1:0] load_id_i,
  input  logic [FreqW-1:0]  load_freq_i,
  input  logic [TimeW-1:0]  load_time_i,
  output logic [IdBits-1:0] id_o,
  output logic [FreqW-1:0]  freq_o,
  output logic [TimeW-1:0]  time_o
);

  logic [IdBits-1:0] id_q, id_d;
  logic [FreqW-1:0]  freq_q, freq_d;
  logic [TimeW-1:0]  time_q, time_d;

  always_comb begin
    id_d   = id_q;
    freq_d = freq_q;
    time_d = time_q;
    if (op_i.load) begin
      id_d   = load_id_i;
      freq_d = load_freq_i;
      time_d = load_time_i;
    end else if (op_i.shift) begin
      id_d   = right_id_i;
      freq_d = right_freq_i;
      time_d = right_time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    freq_q <= freq_d;
    time_q <= time_d;
  end

  assign id_o   = id_q;
  assign freq_o = freq_q;
  assign time_o = time_q;

endmodule

FILE: src/partial_tracker_frame_match_unit.sv
// Top level of the partial tracker frame match unit.
// Peaks are taken one per cycle while busy is low and sorted on arrival in a row of cells.
// The peak carrying last_in_frame starts the match walk: per peak the unit forms its
// breakpoint time, steps past each skipped partial of the previous frame, and emits the
// result; it then commits the new partial list, with busy high throughout the walk.
// Results appear on result_valid_o for one cycle each, in ascending frequency order;
// the receiver cannot stall them. drift_limit is written with cfg_we_i; the user must
// write it only while idle, the block itself does not enforce this. An empty frame
// (action 1) clears the partial list.
`include "partial_tracker_frame_match_unit_macros.svh"
module partial_tracker_frame_match_unit import ptfm_pkg::*; #(
  parameter int unsigned MAX_PEAKS = MaxPeaksDefault,
  parameter int unsigned ID_BITS   = IdBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [FreqW-1:0]         cfg_wdata_i,
  input  logic                     start,
  output logic                     busy,
  input  logic                     action_i,
  input  logic [FreqW-1:0]         peak_freq_i,
  input  logic signed [OffW-1:0]   time_offset_i,
  input  logic [FsW-1:0]           frame_sample_i,
  input  logic [FreqW-1:0]         drift_override_i,
  input  logic [PassW-1:0]         amplitude_i,
  input  logic [PassW-1:0]         bandwidth_i,
  input  logic signed [PassW-1:0]  phase_value_i,
  input  logic                     last_in_frame_i,
  output logic                     result_valid_o,
  output logic [ID_BITS-1:0]       partial_id_o,
  output logic                     started_new_o,
  output logic [FreqW-1:0]         out_freq_o,
  output logic [TimeW-1:0]         breakpoint_time_o,
  output logic [PassW-1:0]         out_amplitude_o,
  output logic [PassW-1:0]         out_bandwidth_o,
  output logic signed [PassW-1:0]  out_phase_o,
  output logic                     id_exhausted_o,
  output logic                     last_of_frame_o
);

  localparam int unsigned CntW = $clog2(MAX_PEAKS + 1);
  localparam int unsigned IdxW = $clog2(MAX_PEAKS);
  localparam logic [ID_BITS-1:0] IdMax = '1;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_WALK, ST_DONE} state_e;

  state_e             state_q;
  logic [FreqW-1:0]   drift_limit_q, drift_q;
  logic [FsW-1:0]     fs_q;
  logic [CntW-1:0]    peak_cnt_q, elig_cnt_q, pk_rem_q, el_rem_q;
  logic [IdxW-1:0]    widx_q;
  logic [ID_BITS-1:0] next_id_q;
  logic [TimeW-1:0]   t_q;

  // sort row
  peak_t    pk   [MAX_PEAKS];
  logic     gt   [MAX_PEAKS];
  peak_t    key;
  sort_op_t sop;

  // current and next partial rows
  logic [ID_BITS-1:0] el_id [MAX_PEAKS], nx_id [MAX_PEAKS];
  logic [FreqW-1:0]   el_f  [MAX_PEAKS], nx_f  [MAX_PEAKS];
  logic [TimeW-1:0]   el_t  [MAX_PEAKS], nx_t  [MAX_PEAKS];

  logic accept, do_insert;
  assign accept    = start && !busy;
  assign do_insert = accept && !action_i && (peak_cnt_q < CntW'(MAX_PEAKS));

  assign key = '{freq: peak_freq_i, offset: time_offset_i, amp: amplitude_i,
                 bw: bandwidth_i, phase: phase_value_i};

  // walk decision for the head peak against the head partial
  logic [FreqW-1:0]   f0, da, db;
  logic               adv, nc, match, emit;
  logic [ID_BITS-1:0] w_id;
  logic [FreqW-1:0]   w_f;
  logic [TimeW-1:0]   w_t;

  always_comb begin
    f0    = pk[0].freq;
    da    = absdiff(el_f[0], f0);
    db    = absdiff(el_f[MAX_PEAKS > 1 ? 1 : 0], f0);
    adv   = (state_q == ST_WALK) && (el_rem_q >= CntW'(2)) && (db < da);
    nc    = (pk_rem_q >= CntW'(2)) && (absdiff(pk[1].freq, el_f[0]) < da);
    match = (el_rem_q != '0) && (da < drift_q) && !nc;
    emit  = (state_q == ST_WALK) && !adv;
    if (match) begin
      w_id = el_id[0];
      if (t_q >= el_t[0]) begin
        w_f = f0;
        w_t = t_q;
      end else begin
        w_f = el_f[0];
        w_t = el_t[0];
      end
    end else begin
      w_id = next_id_q;
      w_f  = f0;
      w_t  = t_q;
    end
  end

  assign sop.insert = do_insert;
  assign sop.pop    = emit;

  for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_row
    peak_t    left, right;
    logic     left_gt;
    elig_op_t eop, nop;
    logic [ID_BITS-1:0] r_id;
    logic [FreqW-1:0]   r_f;
    logic [TimeW-1:0]   r_t;

    if (i == 0) begin : g_first
      assign left    = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left    = pk[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == MAX_PEAKS - 1) begin : g_last
      assign right = '0;
      assign r_id  = '0;
      assign r_f   = '0;
      assign r_t   = '0;
    end else begin : g_inner
      assign right = pk[i+1];
      assign r_id  = el_id[i+1];
      assign r_f   = el_f[i+1];
      assign r_t   = el_t[i+1];
    end

    ptfm_sort_cell u_sort (
      .clk_i    (clk_i),
      .op_i     (sop),
      .vld_i    (CntW'(i) < peak_cnt_q),
      .key_i    (key),
      .left_i   (left),
      .left_gt_i(left_gt),
      .right_i  (right),
      .gt_o     (gt[i]),
      .data_o   (pk[i])
    );

    assign eop.shift = adv || (emit && match);
    assign eop.load  = (state_q == ST_DONE);

    ptfm_elig_cell #(.IdBits(ID_BITS)) u_elig (
      .clk_i       (clk_i),
      .op_i        (eop),
      .right_id_i  (r_id),
      .right_freq_i(r_f),
      .right_time_i(r_t),
      .load_id_i   (nx_id[i]),
      .load_freq_i (nx_f[i]),
      .load_time_i (nx_t[i]),
      .id_o        (el_id[i]),
      .freq_o      (el_f[i]),
      .time_o      (el_t[i])
    );

    assign nop.shift = 1'b0;
    assign nop.load  = emit && (widx_q == IdxW'(i));

    ptfm_elig_cell #(.IdBits(ID_BITS)) u_next (
      .clk_i       (clk_i),
      .op_i        (nop),
      .right_id_i  (r_id),
      .right_freq_i(r_f),
      .right_time_i(r_t),
      .load_id_i   (w_id),
      .load_freq_i (w_f),
      .load_time_i (w_t),
      .id_o        (nx_id[i]),
      .freq_o      (nx_f[i]),
      .time_o      (nx_t[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      drift_limit_q  <= DriftReset;
      peak_cnt_q     <= '0;
      elig_cnt_q     <= '0;
      pk_rem_q       <= '0;
      el_rem_q       <= '0;
      widx_q         <= '0;
      next_id_q      <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) drift_limit_q <= cfg_wdata_i;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (action_i) begin
              peak_cnt_q <= '0;
              elig_cnt_q <= '0;
            end else begin
              if (do_insert) peak_cnt_q <= peak_cnt_q + CntW'(1);
              if (last_in_frame_i) begin
                fs_q     <= frame_sample_i;
                drift_q  <= (drift_override_i != '0) ? drift_override_i : drift_limit_q;
                pk_rem_q <= do_insert ? peak_cnt_q + CntW'(1) : peak_cnt_q;
                el_rem_q <= elig_cnt_q;
                widx_q   <= '0;
                state_q  <= ST_PREP;
              end
            end
          end
        end
        ST_PREP: begin
          t_q     <= bp_time(fs_q, pk[0].offset);
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (adv) begin
            el_rem_q <= el_rem_q - CntW'(1);
          end else begin
            result_valid_o    <= 1'b1;
            partial_id_o      <= w_id;
            started_new_o     <= !match;
            out_freq_o        <= f0;
            breakpoint_time_o <= t_q;
            out_amplitude_o   <= pk[0].amp;
            out_bandwidth_o   <= pk[0].bw;
            out_phase_o       <= pk[0].phase;
            id_exhausted_o    <= !match && (next_id_q == IdMax);
            last_of_frame_o   <= (pk_rem_q == CntW'(1));
            if (match) el_rem_q <= el_rem_q - CntW'(1);
            else if (next_id_q != IdMax) next_id_q <= next_id_q + ID_BITS'(1);
            pk_rem_q <= pk_rem_q - CntW'(1);
            widx_q   <= widx_q + IdxW'(1);
            state_q  <= (pk_rem_q == CntW'(1)) ? ST_DONE : ST_PREP;
          end
        end
        ST_DONE: begin
          elig_cnt_q <= peak_cnt_q;
          peak_cnt_q <= '0;
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);

  `PTFM_ASSERT(a_result_while_busy, result_valid_o |-> busy, "result outside a walk")
  `PTFM_ASSERT(a_last_then_commit, (result_valid_o && last_of_frame_o) |=> !result_valid_o, "late beat")
  `PTFM_ASSERT(a_peak_cnt_bound, peak_cnt_q <= CntW'(MAX_PEAKS), "peak count overflow")
  `PTFM_ASSERT(a_elig_cnt_bound, elig_cnt_q <= CntW'(MAX_PEAKS), "partial count overflow")

endmodule
